// File: rtl/ebml_hdr_pkg.sv
// Shared types and helpers for the element header parser.
// Depends on nothing; imported by every module under rtl/.
package ebml_hdr_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam int IN_DATA_W   = 8;
  localparam int OUT_DATA_W  = 136;
  localparam int ID_W        = 64;
  localparam int LEN_W       = 4;
  localparam int SIZE_W      = 56;

  typedef enum logic [1:0] {
    KIND_FIRST = 2'd0,
    KIND_CONT  = 2'd1,
    KIND_ERR   = 2'd2
  } byte_kind_t;

  typedef struct packed {
    byte_kind_t          kind;
    logic                size_phase;
    logic                last;
    logic [LEN_W-1:0]    length;
    logic [7:0]          data;
  } hdr_beat_t;

  // all 7*len data bits set, len in 1..8
  function automatic logic [SIZE_W-1:0] size_full_mask(input logic [LEN_W-1:0] len);
    logic [SIZE_W-1:0] m;
    begin
      unique case (len)
        4'd1:    m = 56'h00_0000_0000_007F;
        4'd2:    m = 56'h00_0000_0000_3FFF;
        4'd3:    m = 56'h00_0000_001F_FFFF;
        4'd4:    m = 56'h00_0000_0FFF_FFFF;
        4'd5:    m = 56'h00_0007_FFFF_FFFF;
        4'd6:    m = 56'h00_03FF_FFFF_FFFF;
        4'd7:    m = 56'h01_FFFF_FFFF_FFFF;
        4'd8:    m = 56'hFF_FFFF_FFFF_FFFF;
        default: m = '0;
      endcase
      return m;
    end
  endfunction

endpackage

// File: rtl/ebml_hdr_front.sv
// Front end: accepts stream bytes, tracks phase and bytes still due, and
// classifies each byte into a beat for the queue. Uses ebml_hdr_pkg.
module ebml_hdr_front
  import ebml_hdr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,
  input  logic             in_tuser,
  input  logic             q_full,
  output logic             q_push,
  output hdr_beat_t        q_beat
);

  logic       phase_r, phase_nxt;
  logic [2:0] left_r, left_nxt;
  logic       phase_eff;
  logic [2:0] left_eff;
  logic [2:0] zeros;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    zeros = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (in_tdata[i]) zeros = 3'(7 - i);
    end
  end

  always_comb begin
    phase_eff = in_tuser ? 1'b0 : phase_r;
    left_eff  = in_tuser ? 3'd0 : left_r;
    q_beat.size_phase = phase_eff;
    q_beat.length     = '0;
    q_beat.data       = in_tdata;
    if (left_eff == 3'd0) begin
      if (in_tdata == 8'd0) begin
        q_beat.kind = KIND_ERR;
        q_beat.last = 1'b1;
        left_nxt    = 3'd0;
      end else begin
        q_beat.kind   = KIND_FIRST;
        q_beat.length = {1'b0, zeros} + 4'd1;
        q_beat.last   = (zeros == 3'd0);
        left_nxt      = zeros;
        if (phase_eff) q_beat.data = in_tdata & (8'h7F >> zeros);
      end
    end else begin
      q_beat.kind = KIND_CONT;
      q_beat.last = (left_eff == 3'd1);
      left_nxt    = left_eff - 3'd1;
    end
    if (q_beat.kind == KIND_ERR) phase_nxt = 1'b0;
    else if (q_beat.last)        phase_nxt = !phase_eff;
    else                         phase_nxt = phase_eff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      left_r  <= 3'd0;
    end else if (q_push) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
    end
  end

endmodule

// File: rtl/ebml_hdr_queue.sv
// Short beat queue between front and back end.
// Uses ebml_hdr_pkg for the beat type.
module ebml_hdr_queue
  import ebml_hdr_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  hdr_beat_t push_beat,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output hdr_beat_t head_beat
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  hdr_beat_t          slot_r [DEPTH];
  logic [PTR_W-1:0]   wr_r, rd_r;
  logic [CNT_W-1:0]   cnt_r;

  assign full       = (cnt_r == CNT_W'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_beat  = slot_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_r] <= push_beat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
      if (pop)  rd_r <= (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// File: rtl/ebml_hdr_back.sv
// Back end: assembles the ID and size integers from queued beats and holds
// each finished header in the output register. Uses ebml_hdr_pkg.
module ebml_hdr_back
  import ebml_hdr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   head_valid,
  input  hdr_beat_t              head_beat,
  output logic                   pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_DATA_W-1:0]  out_tdata,
  output logic                   out_tuser
);

  logic [ID_W-1:0]       acc_r, acc_nxt;
  logic [LEN_W-1:0]      len_r, len_nxt;
  logic [ID_W-1:0]       held_id_r;
  logic [LEN_W-1:0]      held_len_r;
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                  out_err_r;
  logic                  is_err, emits, id_done;

  assign is_err  = (head_beat.kind == KIND_ERR);
  assign emits   = is_err || (head_beat.last && head_beat.size_phase);
  assign id_done = !is_err && head_beat.last && !head_beat.size_phase;
  assign pop     = head_valid && (!emits || !out_valid_r || out_tready);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_err_r;

  always_comb begin
    if (head_beat.kind == KIND_FIRST) begin
      acc_nxt = {56'd0, head_beat.data};
      len_nxt = head_beat.length;
    end else begin
      acc_nxt = {acc_r[ID_W-9:0], head_beat.data};
      len_nxt = len_r;
    end
    out_data_nxt = '0;
    if (!is_err) begin
      out_data_nxt[63:0]    = held_id_r;
      out_data_nxt[67:64]   = held_len_r;
      out_data_nxt[123:68]  = acc_nxt[SIZE_W-1:0];
      out_data_nxt[127:124] = len_nxt;
      out_data_nxt[128]     = (acc_nxt[SIZE_W-1:0] == size_full_mask(len_nxt));
    end
  end

  always_ff @(posedge clk) begin
    if (pop && !is_err) begin
      acc_r <= acc_nxt;
      len_r <= len_nxt;
    end
    if (pop && id_done) begin
      held_id_r  <= acc_nxt;
      held_len_r <= len_nxt;
    end
    if (pop && emits) begin
      out_data_r <= out_data_nxt;
      out_err_r  <= is_err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop && emits) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule

// File: rtl/ebml_element_header_parser.sv
// Top level of the element header parser: front end, beat queue, back end.
// Depends on ebml_hdr_pkg, ebml_hdr_front, ebml_hdr_queue, ebml_hdr_back.
//
// Takes one container byte per beat and decodes element headers: an ID
// integer with its marker bit kept, then a size integer with the marker
// stripped, each 1..8 bytes long by the first set bit of its first byte.
// One result beat leaves per header, or an error beat (tuser high, tdata
// zero) for a zero first byte. in_tuser high drops any partial header and
// makes the byte the first of an ID. A byte is accepted every cycle while
// the queue has room; the front end classifies it combinationally as it is
// written into the queue; the back end consumes one queued beat per cycle
// unless a result meets a stalled full output register. The last size byte
// passes a queue slot, then the output register, before out_tvalid rises.
// The queue absorbs short stalls; longer ones fill it and drop in_tready.
module ebml_element_header_parser
  import ebml_hdr_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_DATA_W-1:0]   in_tdata,   // [7:0] data_byte
  input  logic                   in_tuser,   // [0] restart
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [63:0] element_id, [67:64] id_length, [123:68] data_size,
  // [127:124] size_length, [128] unknown_size, [135:129] zero
  output logic [OUT_DATA_W-1:0]  out_tdata,
  output logic                   out_tuser   // [0] header_error
);

  logic      q_full, q_push, q_pop, q_valid;
  hdr_beat_t q_in, q_head;

  ebml_hdr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_beat    (q_in)
  );

  ebml_hdr_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_beat  (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_beat  (q_head)
  );

  ebml_hdr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_valid),
    .head_beat  (q_head),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
